### design/gost_94_hash_engine_core_macros.svh
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash engine assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GOST_94_HASH_ENGINE_CORE_MACROS_SVH
`define GOST_94_HASH_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define GOST94_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GOST94_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gost94_pkg.sv
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash package
// Item type, S-box rows, C3 constant and the linear maps of the step function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gost94_pkg;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } item_t;

    // Nibble j of row i is S-box i applied to value j.
    localparam logic [63:0] SBOX_ROWS [8] = '{
        64'hFB290ECD7318654A,
        64'h8AEC36719BD204F5,
        64'hD8A625B30149ECF7,
        64'h39BD561E82F0C7A4,
        64'h53DFE081A2C9B467,
        64'h3CE8B51A0F9D4267,
        64'hB926F8C3A50714ED,
        64'hC20DE768F4B59A31
    };

    localparam logic [255:0] C3 = {
        64'hFF00FFFF000000FF, 64'hFF0000FF00FFFF00,
        64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00
    };

    function automatic logic [31:0] round_f(input logic [31:0] x);
        logic [31:0] r;
        logic [63:0] sb;
        for (int i = 0; i < 8; i++) begin
            sb = SBOX_ROWS[i];
            r[4*i +: 4] = sb[{x[4*i +: 4], 2'b00} +: 4];
        end
        return {r[20:0], r[31:21]};
    endfunction

    function automatic logic [255:0] a_map(input logic [255:0] w);
        return {w[63:0] ^ w[127:64], w[255:192], w[191:128], w[127:64]};
    endfunction

    // output byte i+4k takes input byte 8i+k
    function automatic logic [255:0] p_map(input logic [255:0] w);
        logic [255:0] o;
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 8; k++) begin
                o[8*(i+4*k) +: 8] = w[8*(8*i+k) +: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [255:0] psi(input logic [255:0] y);
        return {y[15:0] ^ y[31:16] ^ y[47:32] ^ y[63:48] ^ y[207:192] ^ y[255:240],
                y[255:16]};
    endfunction

    // key word order: 0..7 three times, then 7..0
    function automatic logic [2:0] key_sel(input logic [4:0] rnd);
        return (rnd[4] & rnd[3]) ? ~rnd[2:0] : rnd[2:0];
    endfunction

endpackage

### design/gost_94_hash_engine_core.sv
// Per item: a fetch, one packing step per message byte (up to 8), then a wrap-up.
// Each 32-byte block adds a compression: 32 rounds, 74 shuffle steps, then a handoff.
// Final item adds up to three compressions (data, length, checksum), then 4 words.
// A two-entry item queue lets the input side run ahead of the byte packer.
// aresetn is synchronous, active low; it clears chain, checksum, length and queue.
// ----------------------------------------------------------------------------
// GOST R 34.11-94 hash engine core
// Stream in message chunks, stream out the 256-bit digest as four words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost_94_hash_engine_core
    import gost94_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // chunk_bytes[63:0], byte_count[67:64], zero pad
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word[63:0], word_index[65:64], zero pad
    output logic        m_tlast    // last_word
);

    logic        item_valid, item_ready;
    item_t       item;
    logic [63:0] digest_word;
    logic [1:0]  word_index;

    gost94_fe #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_fe (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .chunk_bytes    (s_tdata[63:0]),
        .byte_count     (s_tdata[67:64]),
        .end_of_message (s_tlast),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item)
    );

    gost94_be u_be (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_tlast)
    );

    assign m_tdata = {6'd0, word_index, digest_word};

endmodule

### design/gost94_fe.sv
// ----------------------------------------------------------------------------
// GOST94 front end
// Accepts chunks, clamps the byte count and queues items for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost94_fe
    import gost94_pkg::*;
#(
    parameter int BYTES_PER_ITEM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] chunk_bytes,
    input  logic [3:0]  byte_count,
    input  logic        end_of_message,
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    localparam logic [3:0] MAX_COUNT = 4'(BYTES_PER_ITEM);

    item_t      q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    item_t      in_item;

    assign s_tready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = s_tvalid & s_tready;
    assign pop        = item_valid & item_ready;

    always_comb begin
        in_item.data  = chunk_bytes;
        in_item.count = (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
        in_item.last  = end_of_message;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

### design/gost94_cmp.sv
// ----------------------------------------------------------------------------
// GOST94 compression unit
// Key generation, four 32-round encryptions side by side, then the shuffle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost94_cmp
    import gost94_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [255:0] h_in,
    input  logic [255:0] m_in,
    output logic         done,
    output logic [255:0] result
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ENC  = 2'd1;
    localparam logic [1:0] C_PSI  = 2'd2;

    localparam logic [6:0] STEP_XOR_M = 7'd11;
    localparam logic [6:0] STEP_XOR_H = 7'd12;
    localparam logic [6:0] STEP_LAST  = 7'd73;

    logic [1:0]   state_reg;
    logic [4:0]   rnd_reg;
    logic [6:0]   step_reg;
    logic         done_reg;
    logic [255:0] h_reg, m_reg, y_reg;
    logic [255:0] key_reg [4];
    logic [31:0]  n0_reg [4];
    logic [31:0]  n1_reg [4];

    logic [255:0] u1, u2, u3, v1, v2, v3;
    logic [255:0] key_new [4];
    logic [31:0]  t_new [4];
    logic [255:0] y_psi;

    always_comb begin
        u1 = a_map(h_in);
        u2 = a_map(u1) ^ C3;
        u3 = a_map(u2);
        v1 = a_map(a_map(m_in));
        v2 = a_map(a_map(v1));
        v3 = a_map(a_map(v2));
        key_new[0] = p_map(h_in ^ m_in);
        key_new[1] = p_map(u1 ^ v1);
        key_new[2] = p_map(u2 ^ v2);
        key_new[3] = p_map(u3 ^ v3);
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            t_new[j] = round_f(n0_reg[j] + key_reg[j][{key_sel(rnd_reg), 5'b0} +: 32])
                       ^ n1_reg[j];
        end
    end

    always_comb begin
        y_psi = psi(y_reg);
        if (step_reg == STEP_XOR_M) y_psi = y_psi ^ m_reg;
        if (step_reg == STEP_XOR_H) y_psi = y_psi ^ h_reg;
    end

    assign done   = done_reg;
    assign result = y_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            h_reg <= h_in;
            m_reg <= m_in;
            for (int j = 0; j < 4; j++) begin
                key_reg[j] <= key_new[j];
                n0_reg[j]  <= h_in[64*j +: 32];
                n1_reg[j]  <= h_in[64*j+32 +: 32];
            end
        end else if (state_reg == C_ENC) begin
            for (int j = 0; j < 4; j++) begin
                n0_reg[j] <= t_new[j];
                n1_reg[j] <= n0_reg[j];
            end
            // the last round's halves form the encrypted words
            for (int j = 0; j < 4; j++) begin
                y_reg[64*j +: 64] <= {t_new[j], n0_reg[j]};
            end
        end else if (state_reg == C_PSI) begin
            y_reg <= y_psi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            rnd_reg   <= 5'd0;
            step_reg  <= 7'd0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        rnd_reg   <= 5'd0;
                        state_reg <= C_ENC;
                    end
                end
                C_ENC: begin
                    rnd_reg <= rnd_reg + 5'd1;
                    if (rnd_reg == 5'd31) begin
                        step_reg  <= 7'd0;
                        state_reg <= C_PSI;
                    end
                end
                C_PSI: begin
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == STEP_LAST) begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

### design/gost94_be.sv
// ----------------------------------------------------------------------------
// GOST94 back end
// Packs bytes into blocks, runs compressions, finalizes and emits the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost94_be
    import gost94_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BYTE = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [255:0] buf_reg, buf_next;
    logic [4:0]   fill_reg, fill_next;
    logic [255:0] chain_reg, chain_next;
    logic [255:0] csum_reg, csum_next;
    logic [255:0] blen_reg, blen_next;
    logic [63:0]  data_reg, data_next;
    logic [3:0]   left_reg, left_next;
    logic         last_reg, last_next;
    logic [1:0]   idx_reg, idx_next;

    logic         cmp_start, cmp_done;
    logic [255:0] cmp_h, cmp_m, cmp_result;

    gost94_cmp u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmp_start),
        .h_in    (cmp_h),
        .m_in    (cmp_m),
        .done    (cmp_done),
        .result  (cmp_result)
    );

    // the checksum block starts straight from the length block's result
    assign cmp_h = cmp_done ? cmp_result : chain_reg;

    assign item_ready  = (state_reg == S_IDLE);
    assign m_tvalid    = (state_reg == S_OUT);
    assign digest_word = chain_reg[{idx_reg, 6'b0} +: 64];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    always_comb begin
        state_next = state_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        chain_next = chain_reg;
        csum_next  = csum_reg;
        blen_next  = blen_reg;
        data_next  = data_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        cmp_start  = 1'b0;
        cmp_m      = buf_reg;
        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    data_next  = item.data;
                    left_next  = item.count;
                    last_next  = item.last;
                    blen_next  = blen_reg + {249'd0, item.count, 3'b000};
                    state_next = S_BYTE;
                end
            end
            S_BYTE: begin
                if (left_reg != 4'd0) begin
                    buf_next[{fill_reg, 3'b000} +: 8] = data_reg[7:0];
                    data_next = {8'd0, data_reg[63:8]};
                    left_next = left_reg - 4'd1;
                    fill_next = fill_reg + 5'd1;
                    if (fill_reg == 5'd31) begin
                        cmp_m      = buf_next;
                        cmp_start  = 1'b1;
                        state_next = S_COMP;
                    end
                end else if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (fill_reg != 5'd0) begin
                    // pad the partial block with the zeros already there
                    cmp_start  = 1'b1;
                    state_next = S_COMP;
                end else begin
                    cmp_m      = blen_reg;
                    cmp_start  = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_COMP: begin
                if (cmp_done) begin
                    chain_next = cmp_result;
                    csum_next  = csum_reg + buf_reg;
                    buf_next   = 256'd0;
                    fill_next  = 5'd0;
                    state_next = S_BYTE;
                end
            end
            S_LEN: begin
                if (cmp_done) begin
                    chain_next = cmp_result;
                    cmp_m      = csum_reg;
                    cmp_start  = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (cmp_done) begin
                    chain_next = cmp_result;
                    idx_next   = 2'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        chain_next = 256'd0;
                        csum_next  = 256'd0;
                        blen_next  = 256'd0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        left_reg <= left_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            buf_reg   <= 256'd0;
            fill_reg  <= 5'd0;
            chain_reg <= 256'd0;
            csum_reg  <= 256'd0;
            blen_reg  <= 256'd0;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            chain_reg <= chain_next;
            csum_reg  <= csum_next;
            blen_reg  <= blen_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### design/gost94_chk.sv
// ----------------------------------------------------------------------------
// GOST94 port checker
// Watches the result stream of the hash engine core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gost_94_hash_engine_core_macros.svh"

module gost94_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    `GOST94_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `GOST94_ASSERT_NOW(a_last_idx, m_tvalid, m_tlast == (m_tdata[65:64] == 2'd3), "tlast not on word three")
    `GOST94_ASSERT_NEXT(a_order, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[65:64] == 2'($past(m_tdata[65:64]) + 2'd1)), "digest words out of order")
    `GOST94_ASSERT_NEXT(a_end, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after final word")

endmodule

bind gost_94_hash_engine_core gost94_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
